// ===== src/ntm_pkg.sv =====
// Shared types, constants and pair tables for the nearest-neighbor melting
// temperature block. No dependencies.
package ntm_pkg;

  localparam int CNT_W  = 8;
  localparam int DH_W   = 16;
  localparam int DS_W   = 21;
  localparam int H_W    = 18;
  localparam int S_W    = 23;
  localparam int DIV_W  = 64;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] DIV_STEPS = 7'd64;

  localparam logic signed [H_W-1:0] PEN_DH = 18'sd22;
  localparam logic signed [S_W-1:0] PEN_DS = 23'sd690;
  localparam logic signed [DIV_W-1:0] KELVIN_CENTI = 64'sd27315;
  localparam logic signed [DIV_W-1:0] TM_NUM = 64'sd100 <<< 40;
  localparam logic signed [15:0] TM_MAX = 16'sd32767;
  localparam logic signed [15:0] TM_MIN = -16'sd32768;

  localparam logic [2:0] REG_ENTHALPY_INIT = 3'd0;
  localparam logic [2:0] REG_ENTROPY_INIT  = 3'd1;
  localparam logic [2:0] REG_SALT_CONST    = 3'd2;
  localparam logic [2:0] REG_SALT_GC       = 3'd3;
  localparam logic [2:0] REG_SALT_LEN      = 3'd4;

  localparam logic [1:0] OP_PAIR  = 2'd0;
  localparam logic [1:0] OP_GC    = 2'd1;
  localparam logic [1:0] OP_LEN   = 2'd2;
  localparam logic [1:0] OP_RECIP = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_LOAD, ST_WAIT, ST_CHK, ST_OUT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]       length;
    logic [CNT_W-1:0]       gc;
    logic                   first_at;
    logic                   prev_at;
    logic signed [DH_W-1:0] dh_sum;
    logic signed [DS_W-1:0] ds_sum;
    logic                   dropped;
  } win_t;

  function automatic logic signed [7:0] pair_dh(input logic [3:0] k);
    logic signed [7:0] v;
    case (k)
      4'd0: v = -8'sd76;   4'd1: v = -8'sd84;   4'd2: v = -8'sd78;   4'd3: v = -8'sd72;
      4'd4: v = -8'sd85;   4'd5: v = -8'sd80;   4'd6: v = -8'sd106;  4'd7: v = -8'sd78;
      4'd8: v = -8'sd82;   4'd9: v = -8'sd98;   4'd10: v = -8'sd80;  4'd11: v = -8'sd84;
      4'd12: v = -8'sd72;  4'd13: v = -8'sd82;  4'd14: v = -8'sd85;  4'd15: v = -8'sd76;
      default: v = 8'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [12:0] pair_ds(input logic [3:0] k);
    logic signed [12:0] v;
    case (k)
      4'd0: v = -13'sd2130;  4'd1: v = -13'sd2240;  4'd2: v = -13'sd2100;
      4'd3: v = -13'sd2040;  4'd4: v = -13'sd2270;  4'd5: v = -13'sd1990;
      4'd6: v = -13'sd2720;  4'd7: v = -13'sd2100;  4'd8: v = -13'sd2220;
      4'd9: v = -13'sd2440;  4'd10: v = -13'sd1990; 4'd11: v = -13'sd2240;
      4'd12: v = -13'sd2130; 4'd13: v = -13'sd2220; 4'd14: v = -13'sd2270;
      4'd15: v = -13'sd2130;
      default: v = 13'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ntm_div.sv =====
// Shared signed divider, one quotient bit per cycle, rounds to nearest with
// ties away from zero. Depends on ntm_pkg.
module ntm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ntm_pkg::DIV_W-1:0]  num,
  input  logic signed [ntm_pkg::DIV_W-1:0]  den,
  output logic                              done,
  output logic signed [ntm_pkg::DIV_W-1:0]  quo_out
);
  import ntm_pkg::*;

  logic signed [DIV_W-1:0] n_r, d_r;
  logic [DIV_W-1:0] quo, dv, mn, md;
  logic [DIV_W:0] rem, trial;
  logic [STEP_W-1:0] cnt;
  logic prep, run, neg;

  assign mn = n_r[DIV_W-1] ? DIV_W'(-n_r) : DIV_W'(n_r);
  assign md = d_r[DIV_W-1] ? DIV_W'(-d_r) : DIV_W'(d_r);
  assign trial = {rem[DIV_W-1:0], quo[DIV_W-1]} - {1'b0, dv};
  assign quo_out = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      prep <= 1'b0;
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        n_r  <= num;
        d_r  <= den;
        prep <= 1'b1;
        done <= 1'b0;
      end else if (prep) begin
        prep <= 1'b0;
        neg  <= n_r[DIV_W-1] ^ d_r[DIV_W-1];
        dv   <= md;
        quo  <= mn + (md >> 1);
        rem  <= '0;
        cnt  <= DIV_STEPS;
        run  <= 1'b1;
        done <= 1'b0;
      end else if (run) begin
        if (!trial[DIV_W]) begin
          rem <= trial;
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= {rem[DIV_W-1:0], quo[DIV_W-1]};
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt  <= cnt - 1'b1;
        done <= (cnt == 7'd1);
        if (cnt == 7'd1) run <= 1'b0;
      end else begin
        done <= 1'b0;
      end
    end
  end
endmodule

// ===== src/ntm_window.sv =====
// Window state: pair enthalpy and entropy sums, GC count, length and end bases.
// Depends on ntm_pkg.
module ntm_window #(
  parameter int MAX_WINDOW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         base,
  input  logic               start,
  output ntm_pkg::win_t      win
);
  import ntm_pkg::*;

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_WINDOW);

  logic [1:0] prev_base, first_base;
  logic [CNT_W-1:0] length_count, gc_count;
  logic signed [DH_W-1:0] dh_sum;
  logic signed [DS_W-1:0] ds_sum;
  logic dropped;
  logic is_gc;
  logic [3:0] k;

  assign is_gc = (base == 2'd1) || (base == 2'd2);
  assign k = {prev_base, base};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_base    <= '0;
      first_base   <= '0;
      length_count <= '0;
      gc_count     <= '0;
      dh_sum       <= '0;
      ds_sum       <= '0;
      dropped      <= 1'b0;
    end else if (accept) begin
      dropped <= 1'b0;
      if (start || length_count == '0) begin
        first_base   <= base;
        prev_base    <= base;
        dh_sum       <= '0;
        ds_sum       <= '0;
        gc_count     <= is_gc ? CNT_W'(1) : '0;
        length_count <= CNT_W'(1);
      end else if (length_count >= MAX_LEN) begin
        dropped <= 1'b1;
      end else begin
        dh_sum       <= dh_sum + DH_W'(pair_dh(k));
        ds_sum       <= ds_sum + DS_W'(pair_ds(k));
        gc_count     <= gc_count + CNT_W'(is_gc);
        length_count <= length_count + 1'b1;
        prev_base    <= base;
      end
    end
  end

  always_comb begin
    win.length   = length_count;
    win.gc       = gc_count;
    win.first_at = (first_base == 2'd0) || (first_base == 2'd3);
    win.prev_at  = (prev_base == 2'd0) || (prev_base == 2'd3);
    win.dh_sum   = dh_sum;
    win.ds_sum   = ds_sum;
    win.dropped  = dropped;
  end
endmodule

// ===== src/nearest_neighbor_dna_melting_temp.sv =====
// DNA duplex melting temperature, one result item per base item.
// Each item runs up to four 64-step divisions on the shared divider (pair term,
// GC term, length term, reciprocal); a zero sum after the length term skips the reciprocal.
// One item at a time; a finished result may wait while the next item runs.
// Single-base windows and zero enthalpy skip the divider and go straight to output.
// Synchronous active-high reset clears window state and restores registers.
module nearest_neighbor_dna_melting_temp #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // base_code[1:0], zero fill
  input  logic [0:0]  s_tuser,   // start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tm_centi_celsius[15:0], window_length[22:16], zero fill
  output logic [1:0]  m_tuser,   // valid_res, overflow
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ntm_pkg::*;

  logic signed [7:0]  enthalpy_init;
  logic signed [14:0] entropy_init;
  logic signed [31:0] salt_const_term, salt_gc_term, salt_len_term;

  state_t state, state_next;
  logic [1:0] op;
  logic signed [DIV_W-1:0] acc, num, den, q, tm_full;
  logic signed [H_W-1:0] h, h_r;
  logic signed [S_W-1:0] s, s_r;
  logic div_start, div_done, accept;
  win_t win;
  logic signed [15:0] res_tm;
  logic res_valid, res_ovf;
  logic [8:0] len_ext;
  logic out_free;

  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  ntm_window #(.MAX_WINDOW(MAX_WINDOW)) u_window (
    .clk(clk), .rst(rst), .accept(accept), .base(s_tdata[1:0]),
    .start(s_tuser[0]), .win(win)
  );

  ntm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quo_out(q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enthalpy_init   <= 8'sd2;
      entropy_init    <= -15'sd3773;
      salt_const_term <= 32'sd112500000;
      salt_gc_term    <= -32'sd57640000;
      salt_len_term   <= -32'sd359100000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTHALPY_INIT: enthalpy_init   <= cfg_data[7:0];
        REG_ENTROPY_INIT:  entropy_init    <= cfg_data[14:0];
        REG_SALT_CONST:    salt_const_term <= cfg_data;
        REG_SALT_GC:       salt_gc_term    <= cfg_data;
        REG_SALT_LEN:      salt_len_term   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    h = H_W'(enthalpy_init) + H_W'(win.dh_sum)
        + (win.first_at ? PEN_DH : '0) + (win.prev_at ? PEN_DH : '0);
    s = S_W'(entropy_init) + S_W'(win.ds_sum)
        + (win.first_at ? PEN_DS : '0) + (win.prev_at ? PEN_DS : '0);
  end

  always_comb begin
    case (op)
      OP_PAIR: begin
        num = DIV_W'(s_r) <<< 40;
        den = DIV_W'(h_r * 18'sd10000);
      end
      OP_GC: begin
        num = DIV_W'(salt_gc_term * $signed({1'b0, win.gc}));
        den = DIV_W'({1'b0, win.length});
      end
      OP_LEN: begin
        num = DIV_W'(salt_len_term);
        den = DIV_W'({1'b0, win.length - 1'b1, 1'b0});
      end
      default: begin
        num = TM_NUM;
        den = acc;
      end
    endcase
  end

  assign tm_full = q - KELVIN_CENTI;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EVAL;
      ST_EVAL: begin
        if (win.length < CNT_W'(2) || h == '0) state_next = ST_OUT;
        else state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          if (op == OP_LEN) state_next = ST_CHK;
          else if (op == OP_RECIP) state_next = ST_OUT;
          else state_next = ST_LOAD;
        end
      end
      ST_CHK: state_next = (acc == '0) ? ST_OUT : ST_LOAD;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = (state == ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_EVAL: begin
        h_r       <= h;
        s_r       <= s;
        op        <= OP_PAIR;
        acc       <= DIV_W'(salt_const_term);
        res_valid <= (win.length >= CNT_W'(2));
        res_ovf   <= win.dropped || (win.length >= CNT_W'(2) && h == '0);
        res_tm    <= (win.length >= CNT_W'(2) && h == '0) ? TM_MAX : '0;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (op == OP_RECIP) begin
            if (tm_full > DIV_W'(TM_MAX)) begin
              res_tm  <= TM_MAX;
              res_ovf <= 1'b1;
            end else if (tm_full < DIV_W'(TM_MIN)) begin
              res_tm  <= TM_MIN;
              res_ovf <= 1'b1;
            end else begin
              res_tm <= tm_full[15:0];
            end
          end else begin
            acc <= acc + q;
            op  <= op + 1'b1;
          end
        end
      end
      ST_CHK: begin
        if (acc == '0) begin
          res_tm  <= TM_MAX;
          res_ovf <= 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= {1'b0, (len_ext > 9'd127) ? 7'd127 : len_ext[6:0], res_tm};
          m_tuser <= {res_ovf, res_valid};
        end
      end
      default: ;
    endcase
  end

  assign len_ext = 9'(win.length);
endmodule
